// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the checker file xpt_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held
`define XPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also runs through reset
`define XPT_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/xpt_pkg.sv =====
// ---------------------------------------------------------------------------
// xpt_pkg
// Types, codes and byte classes of the XML push tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package xpt_pkg;

    // context codes
    localparam logic [1:0] CTX_TEXT = 2'd0;
    localparam logic [1:0] CTX_TAG  = 2'd1;
    localparam logic [1:0] CTX_ATTR = 2'd2;
    localparam logic [1:0] CTX_SKIP = 2'd3;

    // phase codes
    localparam logic [2:0] PH_INI      = 3'd0;
    localparam logic [2:0] PH_OPENING  = 3'd1;
    localparam logic [2:0] PH_CLOSING  = 3'd2;
    localparam logic [2:0] PH_KEY      = 3'd3;
    localparam logic [2:0] PH_WANT_VAL = 3'd4;
    localparam logic [2:0] PH_VAL      = 3'd5;
    localparam logic [2:0] PH_LAV      = 3'd6;

    // event codes
    localparam logic [3:0] EV_TEXT     = 4'd0;
    localparam logic [3:0] EV_NAME     = 4'd1;
    localparam logic [3:0] EV_OPEN     = 4'd2;
    localparam logic [3:0] EV_CLOSE    = 4'd3;
    localparam logic [3:0] EV_KEY      = 4'd4;
    localparam logic [3:0] EV_VALUE    = 4'd5;
    localparam logic [3:0] EV_DONE     = 4'd6;
    localparam logic [3:0] EV_KEY_ONLY = 4'd7;
    localparam logic [3:0] EV_CLEAR    = 4'd8;
    localparam logic [3:0] EV_ERROR    = 4'd9;

    // special bytes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // one output event
    typedef struct packed {
        logic [3:0] code;
        logic [7:0] value;
        logic       last;
    } t_event;

    // events produced by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
    } t_step_res;

    function automatic logic f_is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic f_is_ws(input logic [7:0] c);
        return c inside {CH_TAB, CH_LF, CH_CR, CH_SPACE};
    endfunction

    function automatic logic f_is_start(input logic [7:0] c);
        return f_is_alpha(c) || (c == CH_USCORE) || (c == CH_COLON) || c[7];
    endfunction

    function automatic logic f_is_key(input logic [7:0] c);
        return f_is_start(c) || f_is_digit(c);
    endfunction

    function automatic logic f_is_name(input logic [7:0] c);
        return f_is_key(c) || (c == CH_DASH) || (c == CH_DOT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xpt_in_if.sv =====
// ---------------------------------------------------------------------------
// xpt_in_if
// Byte input channel: valid/ready with one byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface xpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/xpt_out_if.sv =====
// ---------------------------------------------------------------------------
// xpt_out_if
// Event output channel: valid/ready with one event per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface xpt_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic [7:0] byte_value;
    logic       last_event;

    modport source (output valid, output event_code, output byte_value,
                    output last_event, input ready);
    modport sink   (input valid, input event_code, input byte_value,
                    input last_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/xpt_step.sv =====
// ---------------------------------------------------------------------------
// xpt_step
// Tokenizer state and the per-byte classifier: one byte in, 0..2 events out.
// ---------------------------------------------------------------------------
`default_nettype none

module xpt_step
    import xpt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_char_byte,
    output t_step_res       o_res
);

    logic [1:0] r_ctx, n_ctx;
    logic [2:0] r_ph, n_ph;
    logic [1:0] r_rc, n_rc;
    logic [7:0] r_term, n_term;
    logic       r_cv, n_cv;

    logic [1:0] cnt;
    logic [3:0] ev_code [2];
    logic [7:0] ev_byte [2];
    logic       do_tag;
    logic [7:0] c;

    assign c = i_char_byte;

    // next state and events for the current byte
    always_comb begin
        n_ctx  = r_ctx;
        n_ph   = r_ph;
        n_rc   = r_rc;
        n_term = r_term;
        n_cv   = r_cv;
        cnt    = 2'd0;
        do_tag = 1'b0;
        ev_code[0] = EV_TEXT;
        ev_code[1] = EV_TEXT;
        ev_byte[0] = 8'd0;
        ev_byte[1] = 8'd0;

        case (r_ctx)
            CTX_TEXT: begin
                if (c == CH_LT) begin
                    n_ctx = CTX_TAG;
                end else begin
                    ev_code[cnt[0]] = EV_TEXT;
                    ev_byte[cnt[0]] = c;
                    cnt = cnt + 2'd1;
                end
            end
            CTX_TAG: begin
                do_tag = 1'b1;
            end
            CTX_ATTR: begin
                case (r_ph)
                    PH_LAV: begin
                        if (f_is_start(c)) begin
                            ev_code[cnt[0]] = EV_VALUE;
                            ev_byte[cnt[0]] = c;
                            cnt = cnt + 2'd1;
                        end else if (f_is_ws(c)) begin
                            ev_code[cnt[0]] = EV_DONE;
                            cnt = cnt + 2'd1;
                            n_ph = PH_INI;
                        end else begin
                            ev_code[cnt[0]] = EV_DONE;
                            cnt = cnt + 2'd1;
                            n_ph   = PH_OPENING;
                            n_ctx  = CTX_TAG;
                            do_tag = 1'b1;
                        end
                    end
                    PH_VAL: begin
                        if (f_is_ws(c)) begin
                            n_ph = r_ph;
                        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                            n_term = c;
                            n_ph   = PH_LAV;
                            n_rc   = CTX_ATTR;
                            n_cv   = 1'b1;
                            n_ctx  = CTX_SKIP;
                        end else if (f_is_key(c)) begin
                            ev_code[cnt[0]] = EV_VALUE;
                            ev_byte[cnt[0]] = c;
                            cnt = cnt + 2'd1;
                            n_ph = PH_LAV;
                        end else begin
                            n_ph   = PH_OPENING;
                            n_ctx  = CTX_TAG;
                            do_tag = 1'b1;
                        end
                    end
                    PH_WANT_VAL: begin
                        if (c == CH_EQ) begin
                            n_ph = PH_VAL;
                        end else if (f_is_ws(c)) begin
                            n_ph = r_ph;
                        end else if (f_is_start(c)) begin
                            // previous key had no value, a new key starts
                            ev_code[0] = EV_KEY_ONLY;
                            ev_code[1] = EV_KEY;
                            ev_byte[1] = c;
                            cnt  = 2'd2;
                            n_ph = PH_KEY;
                        end else begin
                            n_ph   = PH_OPENING;
                            n_ctx  = CTX_TAG;
                            do_tag = 1'b1;
                        end
                    end
                    PH_KEY: begin
                        // other bytes are dropped, key phase kept
                        if (f_is_key(c)) begin
                            ev_code[cnt[0]] = EV_KEY;
                            ev_byte[cnt[0]] = c;
                            cnt = cnt + 2'd1;
                        end else if (c == CH_EQ) begin
                            n_ph = PH_VAL;
                        end else if (f_is_ws(c)) begin
                            n_ph = PH_WANT_VAL;
                        end
                    end
                    default: begin
                        // initial attribute phase; tag phases land here too
                        if (f_is_start(c)) begin
                            ev_code[cnt[0]] = EV_KEY;
                            ev_byte[cnt[0]] = c;
                            cnt = cnt + 2'd1;
                            n_ph = PH_KEY;
                        end else if (!f_is_ws(c)) begin
                            n_ph   = PH_OPENING;
                            n_ctx  = CTX_TAG;
                            do_tag = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                // skip until terminator
                if (c != r_term) begin
                    if (r_cv) begin
                        ev_code[cnt[0]] = EV_VALUE;
                        ev_byte[cnt[0]] = c;
                        cnt = cnt + 2'd1;
                    end
                end else begin
                    n_ctx = r_rc;
                end
            end
        endcase

        // tag byte handling, also for bytes handed back from attributes
        if (do_tag) begin
            case (n_ph)
                PH_INI: begin
                    if (f_is_start(c)) begin
                        n_ph = PH_OPENING;
                        ev_code[cnt[0]] = EV_NAME;
                        ev_byte[cnt[0]] = c;
                        cnt = cnt + 2'd1;
                    end else if (c == CH_QMARK) begin
                        n_term = c;
                        n_rc   = CTX_TAG;
                        n_ctx  = CTX_SKIP;
                    end else if (c == CH_GT) begin
                        n_ctx = CTX_TEXT;
                    end else if (c == CH_SLASH) begin
                        n_term = 8'd0;
                        n_cv   = 1'b0;
                        n_ph   = PH_CLOSING;
                    end else begin
                        ev_code[cnt[0]] = EV_ERROR;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                    end
                end
                PH_OPENING: begin
                    if (f_is_name(c)) begin
                        ev_code[cnt[0]] = EV_NAME;
                        ev_byte[cnt[0]] = c;
                        cnt = cnt + 2'd1;
                    end else if (c == CH_SLASH) begin
                        ev_code[cnt[0]] = EV_OPEN;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                        n_term = 8'd0;
                        n_cv   = 1'b0;
                        n_ph   = PH_CLOSING;
                    end else if (c == CH_GT) begin
                        ev_code[cnt[0]] = EV_OPEN;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                        n_term = 8'd0;
                        n_cv   = 1'b0;
                        n_ph   = PH_INI;
                        n_ctx  = CTX_TEXT;
                    end else if (f_is_ws(c)) begin
                        ev_code[cnt[0]] = EV_CLEAR;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                        n_term = 8'd0;
                        n_cv   = 1'b0;
                        n_ctx  = CTX_ATTR;
                    end else begin
                        ev_code[cnt[0]] = EV_ERROR;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                    end
                end
                PH_CLOSING: begin
                    if (c == CH_GT) begin
                        ev_code[cnt[0]] = EV_CLOSE;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                        n_ph   = PH_INI;
                        n_term = 8'd0;
                        n_cv   = 1'b0;
                        n_ctx  = CTX_TEXT;
                    end else if (f_is_name(c)) begin
                        ev_code[cnt[0]] = EV_NAME;
                        ev_byte[cnt[0]] = c;
                        cnt = cnt + 2'd1;
                    end else begin
                        ev_code[cnt[0]] = EV_ERROR;
                        ev_byte[cnt[0]] = 8'd0;
                        cnt = cnt + 2'd1;
                    end
                end
                default: begin
                    // attribute phase seen in tag context
                    ev_code[cnt[0]] = EV_ERROR;
                    ev_byte[cnt[0]] = 8'd0;
                    cnt = cnt + 2'd1;
                end
            endcase
        end
    end

    // result bundle; nothing is pushed unless the byte is taken
    always_comb begin
        o_res.count     = i_fire ? cnt : 2'd0;
        o_res.ev0.code  = ev_code[0];
        o_res.ev0.value = ev_byte[0];
        o_res.ev0.last  = (cnt == 2'd1);
        o_res.ev1.code  = ev_code[1];
        o_res.ev1.value = ev_byte[1];
        o_res.ev1.last  = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx  <= CTX_TEXT;
            r_ph   <= PH_INI;
            r_rc   <= CTX_TEXT;
            r_term <= 8'd0;
            r_cv   <= 1'b0;
        end else if (i_fire) begin
            r_ctx  <= n_ctx;
            r_ph   <= n_ph;
            r_rc   <= n_rc;
            r_term <= n_term;
            r_cv   <= n_cv;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/xpt_evq.sv =====
// ---------------------------------------------------------------------------
// xpt_evq
// Event queue: takes up to two events a cycle, hands out one beat a cycle while the sink is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module xpt_evq
    import xpt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step_res  i_res,
    output logic            o_room,
    xpt_out_if.source       o_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PTR_W-1:0]   wr_next;
    logic               pop;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_next = f_inc(r_wr);
    assign pop     = o_out.valid && o_out.ready;
    // room for a two-event byte
    assign o_room  = (r_cnt <= CNT_W'(DEPTH - 2));

    // pointer and fill updates
    always_comb begin
        n_wr  = r_wr;
        n_rd  = pop ? f_inc(r_rd) : r_rd;
        n_cnt = r_cnt + CNT_W'(i_res.count) - CNT_W'(pop);
        if (i_res.count == 2'd1) begin
            n_wr = wr_next;
        end else if (i_res.count == 2'd2) begin
            n_wr = f_inc(wr_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_wr] <= i_res.ev0;
        end
        if (i_res.count == 2'd2) begin
            r_mem[wr_next] <= i_res.ev1;
        end
    end

    // head beat
    assign o_out.valid      = (r_cnt != '0);
    assign o_out.event_code = r_mem[r_rd].code;
    assign o_out.byte_value = r_mem[r_rd].value;
    assign o_out.last_event = r_mem[r_rd].last;

endmodule

`default_nettype wire

// ===== rtl/xml_push_tokenizer_core.sv =====
// ---------------------------------------------------------------------------
// xml_push_tokenizer_core
// Streaming XML tokenizer: one byte per beat in, text/tag/attribute events out.
// ---------------------------------------------------------------------------
//  channel  dir  beat                                  accepted when
//  i_in     in   char_byte                             valid && ready
//  o_out    out  event_code, byte_value, last_event    valid && ready
//
//  One byte per cycle sustained; a byte enters the input register, is classified
//  from it once the event queue has room, and its 0..2 events are queued for o_out.
//  A byte is taken only while the event queue has two free entries, so a slow
//  sink or a run of two-event bytes (one output beat per cycle) holds i_in off.
//  Synchronous reset clears context, phase and queue pointers.
// ---------------------------------------------------------------------------
`default_nettype none

module xml_push_tokenizer_core
    import xpt_pkg::*;
#(
    parameter int EVQ_DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    xpt_in_if.sink      i_in,
    xpt_out_if.source   o_out
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       fire;
    t_step_res  step_res;

    // input register
    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || fire;
    assign n_in_valid = i_in.ready ? i_in.valid : r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.char_byte;
        end
    end

    // classifier and state
    xpt_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_char_byte (r_in_byte),
        .o_res       (step_res)
    );

    // result queue
    xpt_evq #(
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (step_res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/xpt_checker.sv =====
// ---------------------------------------------------------------------------
// xpt_checker
// Port-level checks of the tokenizer's event stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module xpt_checker
    import xpt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_ready,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [3:0] i_event_code,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_event
);

    // out of reset: no event pending, input open
    `XPT_ASSERT_NR(a_reset_idle, $past(!i_rst_n) |-> (!i_out_valid && i_in_ready), "not idle after reset")

    // only defined event codes
    `XPT_ASSERT(a_code_range, i_out_valid |-> (i_event_code <= EV_ERROR), "bad event code")

    // non-character events carry a zero byte
    `XPT_ASSERT(a_zero_byte, (i_out_valid && i_event_code != EV_TEXT && i_event_code != EV_NAME && i_event_code != EV_KEY && i_event_code != EV_VALUE) |-> (i_byte_value == 8'd0), "byte on non-char event")

    // the second event of a byte follows right behind the first
    `XPT_ASSERT(a_pair_ready, (i_out_valid && i_out_ready && !i_last_event) |=> i_out_valid, "second event missing")

    // stalled beat holds
    `XPT_ASSERT(a_stall_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_event_code) && $stable(i_byte_value) && $stable(i_last_event)), "stalled beat changed")

endmodule

bind xml_push_tokenizer_core xpt_checker u_xpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_code (o_out.event_code),
    .i_byte_value (o_out.byte_value),
    .i_last_event (o_out.last_event)
);

`default_nettype wire

// ===== tb/tb_xml_push_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_xml_push_tokenizer_core
// Self-checking bench for the XML push tokenizer. A table of directed bytes
// walks text, tags, attributes, quoted values, processing instructions and
// parse errors. After that, random XML fragments and noise are streamed in.
// A local model of the tokenizer predicts the event beats of every accepted
// byte. Each output beat is compared field by field with the oldest event
// still pending. Both channels stall in random bursts, except near the end.
// ---------------------------------------------------------------------------

module tb_xml_push_tokenizer_core;
    import xpt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_BYTES = 1350;

    // one row of stimulus; count/e0/e1 hold a hand-written result when known
    typedef struct packed {
        logic [7:0] ch;
        logic       known;
        logic [1:0] count;
        t_event     e0;
        t_event     e1;
    } t_stim_row;

    localparam t_event NO_EV = '0;

    logic i_clk;
    logic i_rst_n;

    xpt_in_if  byte_ch ();
    xpt_out_if event_ch ();

    xml_push_tokenizer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (event_ch)
    );

    // tokenizer model state
    logic [1:0] tok_ctx;
    logic [2:0] tok_ph;
    logic [1:0] tok_ret;
    logic [7:0] tok_term;
    logic       tok_copy;

    t_event     step_events[$];     // events of the byte being modeled
    t_event     pending_events[$];  // events still owed by the DUT
    logic [7:0] frag_bytes[$];      // random fragment being sent

    int  error_count  = 0;
    int  cycle_count  = 0;
    int  active_bytes = 0;
    int  src_mode     = 0;
    int  src_left     = 0;
    bit  calm         = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // byte classes
    // ------------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        return (low >= "a") && (low <= "z");
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic bit opens_name(input logic [7:0] c);
        return is_letter(c) || (c == CH_USCORE) || (c == CH_COLON) || (c >= 8'h80);
    endfunction

    function automatic bit in_key(input logic [7:0] c);
        return opens_name(c) || ((c >= "0") && (c <= "9"));
    endfunction

    function automatic bit in_name(input logic [7:0] c);
        return in_key(c) || (c == CH_DASH) || (c == CH_DOT);
    endfunction

    // ------------------------------------------------------------------
    // tokenizer model
    // ------------------------------------------------------------------
    function automatic void note(input logic [3:0] code, input logic [7:0] v);
        t_event e;
        e.code  = code;
        e.value = v;
        e.last  = 1'b0;
        if (step_events.size() < 2) step_events.push_back(e);
    endfunction

    function automatic void drop_aux();
        tok_term = '0;
        tok_copy = 1'b0;
    endfunction

    function automatic void tag_step(input logic [7:0] c);
        case (tok_ph)
            PH_INI: begin
                if (opens_name(c)) begin
                    tok_ph = PH_OPENING;
                    note(EV_NAME, c);
                end else if (c == CH_QMARK) begin
                    // processing instruction: skip to the next '?'
                    tok_term = c;
                    tok_ret  = CTX_TAG;
                    tok_ctx  = CTX_SKIP;
                end else if (c == CH_GT) begin
                    tok_ctx = CTX_TEXT;
                end else if (c == CH_SLASH) begin
                    drop_aux();
                    tok_ph = PH_CLOSING;
                end else begin
                    note(EV_ERROR, '0);
                end
            end
            PH_OPENING: begin
                if (in_name(c)) begin
                    note(EV_NAME, c);
                end else if (c == CH_SLASH) begin
                    note(EV_OPEN, '0);
                    drop_aux();
                    tok_ph = PH_CLOSING;
                end else if (c == CH_GT) begin
                    note(EV_OPEN, '0);
                    drop_aux();
                    tok_ph  = PH_INI;
                    tok_ctx = CTX_TEXT;
                end else if (is_blank(c)) begin
                    note(EV_CLEAR, '0);
                    drop_aux();
                    tok_ctx = CTX_ATTR;
                end else begin
                    note(EV_ERROR, '0);
                end
            end
            PH_CLOSING: begin
                if (c == CH_GT) begin
                    note(EV_CLOSE, '0);
                    tok_ph = PH_INI;
                    drop_aux();
                    tok_ctx = CTX_TEXT;
                end else if (in_name(c)) begin
                    note(EV_NAME, c);
                end else begin
                    note(EV_ERROR, '0);
                end
            end
            // attribute phase while in a tag
            default: note(EV_ERROR, '0);
        endcase
    endfunction

    // byte handed back from the attribute context
    function automatic void reenter_tag(input logic [7:0] c);
        tok_ph  = PH_OPENING;
        tok_ctx = CTX_TAG;
        tag_step(c);
    endfunction

    function automatic void attr_step(input logic [7:0] c);
        case (tok_ph)
            PH_LAV: begin
                if (opens_name(c)) begin
                    note(EV_VALUE, c);
                end else if (is_blank(c)) begin
                    note(EV_DONE, '0);
                    tok_ph = PH_INI;
                end else begin
                    note(EV_DONE, '0);
                    reenter_tag(c);
                end
            end
            PH_VAL: begin
                if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                    tok_term = c;
                    tok_ph   = PH_LAV;
                    tok_ret  = CTX_ATTR;
                    tok_copy = 1'b1;
                    tok_ctx  = CTX_SKIP;
                end else if (in_key(c)) begin
                    note(EV_VALUE, c);
                    tok_ph = PH_LAV;
                end else if (!is_blank(c)) begin
                    reenter_tag(c);
                end
            end
            PH_WANT_VAL: begin
                if (c == CH_EQ) begin
                    tok_ph = PH_VAL;
                end else if (opens_name(c)) begin
                    note(EV_KEY_ONLY, '0);
                    note(EV_KEY, c);
                    tok_ph = PH_KEY;
                end else if (!is_blank(c)) begin
                    reenter_tag(c);
                end
            end
            PH_KEY: begin
                // other bytes inside a key are dropped
                if (in_key(c)) note(EV_KEY, c);
                else if (c == CH_EQ) tok_ph = PH_VAL;
                else if (is_blank(c)) tok_ph = PH_WANT_VAL;
            end
            // initial, and tag phases carried over from the tag context
            default: begin
                if (opens_name(c)) begin
                    note(EV_KEY, c);
                    tok_ph = PH_KEY;
                end else if (!is_blank(c)) begin
                    reenter_tag(c);
                end
            end
        endcase
    endfunction

    function automatic void tokenize(input logic [7:0] c);
        step_events.delete();
        case (tok_ctx)
            CTX_TEXT: begin
                if (c == CH_LT) tok_ctx = CTX_TAG;
                else note(EV_TEXT, c);
            end
            CTX_TAG:  tag_step(c);
            CTX_ATTR: attr_step(c);
            default: begin
                // skip until the terminator, then back to the saved context
                if (c != tok_term) begin
                    if (tok_copy) note(EV_VALUE, c);
                end else begin
                    tok_ctx = tok_ret;
                end
            end
        endcase
        if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // model one accepted beat and queue what it owes
    function automatic void accept_byte(input t_stim_row r);
        logic [15:0] was;
        was = {tok_ctx, tok_ph, tok_ret, tok_term, tok_copy};
        tokenize(r.ch);
        if (step_events.size() != 0 || was != {tok_ctx, tok_ph, tok_ret, tok_term, tok_copy})
            active_bytes++;
        if (r.known) begin
            if (r.count >= 2'd1) pending_events.push_back(r.e0);
            if (r.count == 2'd2) pending_events.push_back(r.e1);
        end else begin
            foreach (step_events[k]) pending_events.push_back(step_events[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_event ev(input logic [3:0] code, input logic [7:0] v,
                                  input logic last);
        t_event e;
        e.code  = code;
        e.value = v;
        e.last  = last;
        return e;
    endfunction

    function automatic t_stim_row row_known(input logic [7:0] ch, input logic [1:0] count,
                                            input t_event e0, input t_event e1);
        t_stim_row r;
        r.ch    = ch;
        r.known = 1'b1;
        r.count = count;
        r.e0    = e0;
        r.e1    = e1;
        return r;
    endfunction

    function automatic t_stim_row row_pred(input logic [7:0] ch);
        return row_known(ch, 2'd0, NO_EV, NO_EV) & ~{8'h00, 1'b1, 2'b00, NO_EV, NO_EV};
    endfunction

    function automatic bit idle_roll(input int mode);
        case (mode)
            0:       return 1'b0;
            1:       return $urandom_range(0, 7) == 0;
            default: return $urandom_range(0, 2) == 0;
        endcase
    endfunction

    function automatic logic [7:0] pick_start();
        case ($urandom_range(0, 3))
            0:       return 8'h41 + 8'($urandom_range(0, 25));
            1:       return 8'h61 + 8'($urandom_range(0, 25));
            2:       return $urandom_range(0, 1) ? CH_USCORE : CH_COLON;
            default: return 8'h80 | 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 4) == 0) return 8'h30 + 8'($urandom_range(0, 9));
        return pick_start();
    endfunction

    function automatic logic [7:0] pick_name();
        case ($urandom_range(0, 7))
            0:       return CH_DASH;
            1:       return CH_DOT;
            default: return pick_key();
        endcase
    endfunction

    // any byte except one
    function automatic logic [7:0] pick_other(input logic [7:0] excl);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == excl);
        return c;
    endfunction

    function automatic void add_blanks(input int lo, input int hi);
        logic [7:0] ws[4];
        ws = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        repeat ($urandom_range(lo, hi)) frag_bytes.push_back(ws[$urandom_range(0, 3)]);
    endfunction

    // start tag with 0..3 attributes, sometimes self-closing
    function automatic void add_open_tag();
        int         form;
        logic [7:0] q;
        frag_bytes.push_back(CH_LT);
        frag_bytes.push_back(pick_start());
        repeat ($urandom_range(0, 5)) frag_bytes.push_back(pick_name());
        repeat ($urandom_range(0, 3)) begin
            add_blanks(1, 2);
            frag_bytes.push_back(pick_start());
            repeat ($urandom_range(0, 4)) frag_bytes.push_back(pick_key());
            form = $urandom_range(0, 3);
            if (form == 1 || form == 2) begin
                // quoted value, any bytes but the quote inside
                add_blanks(0, 1);
                frag_bytes.push_back(CH_EQ);
                add_blanks(0, 1);
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                frag_bytes.push_back(q);
                repeat ($urandom_range(0, 6)) frag_bytes.push_back(pick_other(q));
                frag_bytes.push_back(q);
            end else if (form == 3) begin
                // bare value
                frag_bytes.push_back(CH_EQ);
                frag_bytes.push_back(pick_key());
                repeat ($urandom_range(0, 4)) frag_bytes.push_back(pick_start());
            end
        end
        add_blanks(0, 1);
        if ($urandom_range(0, 3) == 0) frag_bytes.push_back(CH_SLASH);
        frag_bytes.push_back(CH_GT);
    endfunction

    function automatic void build_fragment();
        int kind;
        frag_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            // character data
            repeat ($urandom_range(1, 6)) frag_bytes.push_back(pick_other(CH_LT));
        end else if (kind < 65) begin
            add_open_tag();
            // broken tag: drop its tail
            if (kind >= 57)
                repeat ($urandom_range(1, frag_bytes.size() - 1)) void'(frag_bytes.pop_back());
        end else if (kind < 80) begin
            frag_bytes.push_back(CH_LT);
            frag_bytes.push_back(CH_SLASH);
            frag_bytes.push_back(pick_start());
            repeat ($urandom_range(0, 4)) frag_bytes.push_back(pick_name());
            frag_bytes.push_back(CH_GT);
        end else if (kind < 88) begin
            // processing instruction
            frag_bytes.push_back(CH_LT);
            frag_bytes.push_back(CH_QMARK);
            repeat ($urandom_range(0, 5)) frag_bytes.push_back(pick_other(CH_QMARK));
            frag_bytes.push_back(CH_QMARK);
            frag_bytes.push_back(CH_GT);
        end else begin
            repeat ($urandom_range(1, 4)) frag_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // input driver: called and returning at a falling edge
    // ------------------------------------------------------------------
    task automatic send_byte(input t_stim_row r);
        if (src_left == 0) begin
            src_mode = $urandom_range(0, 2);
            src_left = $urandom_range(20, 80);
        end
        src_left--;
        if (!calm && idle_roll(src_mode)) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.char_byte <= r.ch;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        accept_byte(r);
        @(negedge i_clk);
    endtask

    // hold the input until every pending event has come out
    task automatic hold_until_drained();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_events.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // output sink with random stall bursts
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int mode_left;
        int sink_mode;
        stall_left = 0;
        mode_left  = 0;
        sink_mode  = 0;
        event_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                sink_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 150);
            end
            mode_left--;
            if (stall_left > 0 && !calm) begin
                event_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                event_ch.ready <= 1'b1;
                if (!calm && idle_roll(sink_mode)) stall_left = $urandom_range(1, 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // event checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                $display("%0t: event beat with none pending: expected none, actual code %0d byte %02h last %0b",
                         $time, event_ch.event_code, event_ch.byte_value, event_ch.last_event);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (event_ch.event_code !== want.code) begin
                    $display("%0t: event_code mismatch: expected %0d, actual %0d",
                             $time, want.code, event_ch.event_code);
                    error_count++;
                end
                if (event_ch.byte_value !== want.value) begin
                    $display("%0t: byte_value mismatch: expected %02h, actual %02h",
                             $time, want.value, event_ch.byte_value);
                    error_count++;
                end
                if (event_ch.last_event !== want.last) begin
                    $display("%0t: last_event mismatch: expected %0b, actual %0b",
                             $time, want.last, event_ch.last_event);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_stim_row stim_table[$];
        bit        mid_drain_done;
        mid_drain_done = 1'b0;

        byte_ch.valid     <= 1'b0;
        byte_ch.char_byte <= '0;
        i_rst_n           <= 1'b0;

        tok_ctx  = CTX_TEXT;
        tok_ph   = PH_INI;
        tok_ret  = CTX_TEXT;
        tok_term = '0;
        tok_copy = 1'b0;

        // text extremes, PI skip back into the tag, tag errors
        stim_table.push_back(row_known(8'h00, 2'd1, ev(EV_TEXT, 8'h00, 1'b1), NO_EV));
        stim_table.push_back(row_known(8'hFF, 2'd1, ev(EV_TEXT, 8'hFF, 1'b1), NO_EV));
        stim_table.push_back(row_known(CH_LT, 2'd0, NO_EV, NO_EV));
        stim_table.push_back(row_known(CH_QMARK, 2'd0, NO_EV, NO_EV));
        stim_table.push_back(row_known(CH_QMARK, 2'd0, NO_EV, NO_EV));
        stim_table.push_back(row_known("#", 2'd1, ev(EV_ERROR, 8'h00, 1'b1), NO_EV));
        stim_table.push_back(row_known(8'h80, 2'd1, ev(EV_NAME, 8'h80, 1'b1), NO_EV));
        // attributes: key-only, quoted, bare; dropped byte inside a key
        stim_table.push_back(row_pred(CH_SPACE));
        stim_table.push_back(row_pred("k"));
        stim_table.push_back(row_pred("!"));
        stim_table.push_back(row_pred(CH_TAB));
        stim_table.push_back(row_pred("z"));
        stim_table.push_back(row_pred(CH_EQ));
        stim_table.push_back(row_pred(CH_DQUOTE));
        stim_table.push_back(row_pred(8'h00));
        stim_table.push_back(row_pred(CH_DQUOTE));
        stim_table.push_back(row_pred(CH_LF));
        stim_table.push_back(row_pred("q"));
        stim_table.push_back(row_pred(CH_EQ));
        stim_table.push_back(row_pred("7"));
        // bad byte after a value: done, then error in the tag
        stim_table.push_back(row_known("!", 2'd2, ev(EV_DONE, 8'h00, 1'b0),
                                       ev(EV_ERROR, 8'h00, 1'b1)));
        stim_table.push_back(row_pred(CH_SLASH));
        stim_table.push_back(row_known("#", 2'd1, ev(EV_ERROR, 8'h00, 1'b1), NO_EV));
        stim_table.push_back(row_pred(CH_GT));
        stim_table.push_back(row_pred("w"));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[k]) send_byte(stim_table[k]);
        hold_until_drained();

        // random fragments
        active_bytes = 0;
        while (active_bytes < RANDOM_BYTES) begin
            if (!mid_drain_done && active_bytes >= RANDOM_BYTES / 2) begin
                hold_until_drained();
                mid_drain_done = 1'b1;
            end
            calm = (active_bytes >= RANDOM_BYTES - 200);
            build_fragment();
            foreach (frag_bytes[k]) send_byte(row_pred(frag_bytes[k]));
        end

        byte_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
